FILE: rtl/edf_pkg.sv
// Shared types and constants for the EDF task scheduler.
// No dependencies; imported by every module of the block.
package edf_pkg;

  localparam int MAX_TASKS_DEF = 5;
  localparam int TIME_BITS_DEF = 8;

  // Serial divider operand widths: budget scaled by 2^16 over an 8-bit period.
  localparam int DVD_W = 24;
  localparam int DVS_W = 8;

  localparam logic [16:0] Q16_ONE = 17'h1_0000;

  localparam logic [1:0] ADD_OK   = 2'd0;
  localparam logic [1:0] ADD_UTIL = 2'd1;
  localparam logic [1:0] ADD_FULL = 2'd2;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] budget;
    logic [7:0] task_period;
  } in_item_t;

  typedef struct packed {
    logic [2:0] running_task;
    logic       deadline_miss;
    logic [2:0] missed_task;
    logic [1:0] add_status;
  } out_item_t;

endpackage

FILE: rtl/edf_mem.sv
// Task table storage: one write port, one read port, registered read data.
// Depends on edf_pkg for the default depth and width.
module edf_mem import edf_pkg::*; #(
  parameter int DEPTH  = MAX_TASKS_DEF,
  parameter int WIDTH  = 24 + 2 * TIME_BITS_DEF,
  parameter int ADDR_W = 3
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

FILE: rtl/edf_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on edf_pkg for operand widths.
module edf_div import edf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVD_W-1:0] quo_r;

  logic [DVS_W:0]   shift_nxt;
  logic             ge_nxt;
  logic [DVS_W-1:0] rem_nxt;

  always_comb begin
    shift_nxt = {rem_r, quo_r[DVD_W-1]};
    ge_nxt    = shift_nxt >= {1'b0, dvs_r};
    rem_nxt   = ge_nxt ? DVS_W'(shift_nxt - {1'b0, dvs_r}) : shift_nxt[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dvs_r  <= divisor;
        quo_r  <= dividend;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[DVD_W-2:0], ge_nxt};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/edf_task_scheduler.sv
// EDF task scheduler top level: sequencer over the task table memory (edf_mem, edf_div).
// Tick: select scan, charge, update scan, then the result; no charge step when no task is
// ready. Add: 24-step serial divider, admission check, then a reload scan when admitted;
// a zero period skips the divider and is refused on utilization. One transaction at a time.
// Reset (rst_n, synchronous, active low) empties the table; entries are not cleared.
module edf_task_scheduler import edf_pkg::*; #(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int ENT_W = 24 + 2 * TIME_BITS;

  // One table entry: static task description plus the running counters.
  typedef struct packed {
    logic [7:0]           budget;
    logic [7:0]           len;
    logic [TIME_BITS-1:0] dl;
    logic [7:0]           bleft;
    logic [TIME_BITS-1:0] ticks;
  } ent_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SEL, S_CHG, S_UPD, S_DIV, S_CHK, S_RLD, S_FIN
  } state_t;

  state_t           state_r;
  in_item_t         in_r;
  logic [CNT_W-1:0] count_r;
  logic [16:0]      sum_r;
  logic [CNT_W-1:0] rd_ptr_r;
  logic             pend_r;
  logic [IDX_W-1:0] pend_idx_r;
  logic             found_r;
  logic [IDX_W-1:0] best_idx_r;
  ent_t             best_ent_r;
  logic             miss_r;
  logic [IDX_W-1:0] miss_idx_r;
  logic [1:0]       status_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  // Memory port and datapath signals.
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  ent_t             mem_wdata;
  logic             mem_re;
  logic [ENT_W-1:0] mem_rdata;
  ent_t             rent;
  logic             issue;
  logic             sel_better;
  ent_t             upd_ent;
  logic             upd_miss;
  ent_t             rld_ent;
  ent_t             new_ent;
  logic [TIME_BITS-1:0] last_tick;
  logic             div_start;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;
  logic [24:0]      sum_ext;
  logic             util_over;
  logic             table_full;
  out_item_t        result;

  edf_mem #(
    .DEPTH  (MAX_TASKS),
    .WIDTH  (ENT_W),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (rd_ptr_r[IDX_W-1:0]),
    .rd_data (mem_rdata)
  );

  // Start the share division as the add transaction is taken; a zero period
  // never reaches the divider.
  assign div_start = (state_r == S_IDLE) && in_valid && (in_data.op == OP_ADD) &&
                     (in_data.task_period != 8'd0);

  edf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({in_data.budget, 16'h0000}),
    .divisor  (in_data.task_period),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign rent  = ent_t'(mem_rdata);
  // Scan pointer issues one read per cycle over the occupied entries.
  assign issue = rd_ptr_r < count_r;

  always_comb begin
    // Selection: ready task with the smallest deadline, then smaller budget left;
    // lower index wins a full tie since later entries must be strictly better.
    sel_better = (rent.bleft != 8'd0) &&
                 (!found_r || (rent.dl < best_ent_r.dl) ||
                  ((rent.dl == best_ent_r.dl) && (rent.bleft < best_ent_r.bleft)));

    // Reload image of the entry just read: fresh deadline, budget and counter.
    rld_ent       = rent;
    rld_ent.dl    = TIME_BITS'({{TIME_BITS{1'b0}}, rent.len});
    rld_ent.bleft = rent.budget;
    rld_ent.ticks = '0;

    // Last tick of the period, wrapped to the counter width.
    last_tick = TIME_BITS'({{TIME_BITS{1'b0}}, rent.len} - (TIME_BITS + 8)'(1));

    // Per-tick update of one entry; a miss leaves the entry untouched.
    upd_ent  = rent;
    upd_miss = 1'b0;
    if (rent.ticks == last_tick) begin
      upd_ent = rld_ent;
    end else if (rent.dl != '0) begin
      upd_ent.dl    = rent.dl - TIME_BITS'(1);
      upd_ent.ticks = rent.ticks + TIME_BITS'(1);
    end else if (rent.bleft != 8'd0) begin
      upd_miss = 1'b1;
    end else begin
      upd_ent.ticks = rent.ticks + TIME_BITS'(1);
    end

    // Image of a newly admitted task.
    new_ent.budget = in_r.budget;
    new_ent.len    = in_r.task_period;
    new_ent.dl     = TIME_BITS'({{TIME_BITS{1'b0}}, in_r.task_period});
    new_ent.bleft  = in_r.budget;
    new_ent.ticks  = '0;

    // Admission checks: utilization first, then room in the table.
    sum_ext    = {8'h00, sum_r} + {1'b0, div_quo};
    util_over  = sum_ext >= 25'(Q16_ONE);
    table_full = count_r >= CNT_W'(MAX_TASKS);

    mem_we    = 1'b0;
    mem_waddr = pend_idx_r;
    mem_wdata = rent;
    mem_re    = 1'b0;
    unique case (state_r)
      S_SEL: begin
        mem_re = issue;
      end
      S_CHG: begin
        // Charge one unit to the selected task before the update walk reads it.
        mem_we          = 1'b1;
        mem_waddr       = best_idx_r;
        mem_wdata       = best_ent_r;
        mem_wdata.bleft = best_ent_r.bleft - 8'd1;
      end
      S_UPD: begin
        mem_re    = issue;
        mem_we    = pend_r && !upd_miss;
        mem_wdata = upd_ent;
      end
      S_CHK: begin
        mem_we    = !util_over && !table_full;
        mem_waddr = count_r[IDX_W-1:0];
        mem_wdata = new_ent;
      end
      S_RLD: begin
        mem_re    = issue;
        mem_we    = pend_r;
        mem_wdata = rld_ent;
      end
      default: begin
      end
    endcase

    // Assemble the result of the finished transaction.
    result = '0;
    if (in_r.op == OP_ADD) begin
      result.add_status = status_r;
    end else begin
      result.running_task  = found_r ? 3'(32'(best_idx_r) + 32'd1) : 3'd0;
      result.deadline_miss = miss_r;
      result.missed_task   = miss_r ? 3'(32'(miss_idx_r)) : 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the result once the downstream side takes it.
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            in_r     <= in_data;
            found_r  <= 1'b0;
            miss_r   <= 1'b0;
            rd_ptr_r <= '0;
            pend_r   <= 1'b0;
            if (in_data.op == OP_TICK) begin
              state_r <= S_SEL;
            end else if (in_data.task_period == 8'd0) begin
              // Zero period counts as unbounded utilization.
              status_r <= ADD_UTIL;
              state_r  <= S_FIN;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_SEL: begin
          rd_ptr_r   <= issue ? rd_ptr_r + CNT_W'(1) : rd_ptr_r;
          pend_r     <= issue;
          pend_idx_r <= rd_ptr_r[IDX_W-1:0];
          if (pend_r && sel_better) begin
            found_r    <= 1'b1;
            best_idx_r <= pend_idx_r;
            best_ent_r <= rent;
          end
          if (!issue && !pend_r) begin
            rd_ptr_r <= '0;
            state_r  <= found_r ? S_CHG : S_UPD;
          end
        end
        S_CHG: begin
          state_r <= S_UPD;
        end
        S_UPD: begin
          rd_ptr_r   <= issue ? rd_ptr_r + CNT_W'(1) : rd_ptr_r;
          pend_r     <= issue;
          pend_idx_r <= rd_ptr_r[IDX_W-1:0];
          if (pend_r && upd_miss) begin
            // Stop the walk at the first missed deadline.
            miss_r     <= 1'b1;
            miss_idx_r <= pend_idx_r;
            pend_r     <= 1'b0;
            state_r    <= S_FIN;
          end else if (!issue && !pend_r) begin
            state_r <= S_FIN;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (util_over) begin
            status_r <= ADD_UTIL;
            state_r  <= S_FIN;
          end else if (table_full) begin
            status_r <= ADD_FULL;
            state_r  <= S_FIN;
          end else begin
            // Admit and restart every task with a reload sweep.
            status_r <= ADD_OK;
            count_r  <= count_r + CNT_W'(1);
            sum_r    <= 17'(sum_ext);
            rd_ptr_r <= '0;
            pend_r   <= 1'b0;
            state_r  <= S_RLD;
          end
        end
        S_RLD: begin
          rd_ptr_r   <= issue ? rd_ptr_r + CNT_W'(1) : rd_ptr_r;
          pend_r     <= issue;
          pend_idx_r <= rd_ptr_r[IDX_W-1:0];
          if (!issue && !pend_r) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          // Hold until the output register is free, then hand the result over.
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_data_r  <= result;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_TASKS))
    else $error("task count above table size");

  a_util_below_one: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r < Q16_ONE)
    else $error("utilization sum reached one");

  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.add_status != ADD_OK &&
                      (out_data_r.deadline_miss || out_data_r.running_task != 3'd0)))
    else $error("result mixes tick and add fields");

  a_div_only_in_add: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside an add");
`endif

endmodule

FILE: sim/edf_sched_sb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the EDF task scheduler testbench: keeps its own copy of the
// task table, predicts one result per accepted transaction and checks results in order.
// Depends on edf_pkg for the transaction types and status codes.
package edf_sched_sb_pkg;
  import edf_pkg::*;

  typedef logic [TIME_BITS_DEF-1:0] tick_t;

  class edf_dispatch_scoreboard;
    logic [7:0]  slot_budget  [MAX_TASKS_DEF];
    logic [7:0]  slot_period  [MAX_TASKS_DEF];
    tick_t       deadline_cnt [MAX_TASKS_DEF];
    logic [7:0]  budget_cnt   [MAX_TASKS_DEF];
    tick_t       period_pos   [MAX_TASKS_DEF];
    int unsigned n_tasks;
    int unsigned util_q16;
    out_item_t   dispatch_q [$];
    int          errors;

    function new();
      n_tasks  = 0;
      util_q16 = 0;
      errors   = 0;
      foreach (slot_budget[i]) begin
        slot_budget[i]  = '0;
        slot_period[i]  = '0;
        deadline_cnt[i] = '0;
        budget_cnt[i]   = '0;
        period_pos[i]   = '0;
      end
    endfunction

    // Admission test: utilization first, then room in the table.
    function logic [1:0] admit_task(logic [7:0] bud, logic [7:0] per);
      int unsigned share;
      if (per == 8'd0) return ADD_UTIL;
      share = (32'(bud) * 32'd65536) / 32'(per);
      if (util_q16 + share >= 32'd65536) return ADD_UTIL;
      if (n_tasks >= MAX_TASKS_DEF) return ADD_FULL;
      slot_budget[n_tasks] = bud;
      slot_period[n_tasks] = per;
      n_tasks++;
      util_q16 += share;
      // Restart every task on a successful admission.
      for (int i = 0; i < n_tasks; i++) begin
        deadline_cnt[i] = tick_t'(slot_period[i]);
        budget_cnt[i]   = slot_budget[i];
        period_pos[i]   = '0;
      end
      return ADD_OK;
    endfunction

    // Select, charge, then update the period counters in index order.
    function out_item_t run_tick();
      out_item_t r;
      int        pick;
      r    = '0;
      pick = -1;
      for (int i = 0; i < n_tasks; i++) begin
        if (budget_cnt[i] != 8'd0) begin
          if (pick < 0 || deadline_cnt[i] < deadline_cnt[pick] ||
              (deadline_cnt[i] == deadline_cnt[pick] && budget_cnt[i] < budget_cnt[pick]))
            pick = i;
        end
      end
      if (pick >= 0) begin
        r.running_task = 3'(pick + 1);
        budget_cnt[pick] = budget_cnt[pick] - 8'd1;
      end
      for (int i = 0; i < n_tasks; i++) begin
        if (period_pos[i] == tick_t'(slot_period[i] - 8'd1)) begin
          deadline_cnt[i] = tick_t'(slot_period[i]);
          budget_cnt[i]   = slot_budget[i];
          period_pos[i]   = '0;
        end else begin
          if (deadline_cnt[i] != '0) begin
            deadline_cnt[i] = deadline_cnt[i] - 1'b1;
          end else if (budget_cnt[i] != 8'd0) begin
            // Stop the walk at the first miss.
            r.deadline_miss = 1'b1;
            r.missed_task   = 3'(i);
            return r;
          end
          period_pos[i] = period_pos[i] + 1'b1;
        end
      end
      return r;
    endfunction

    function void note_input(in_item_t item);
      out_item_t r;
      if (item.op == OP_ADD) begin
        r = '0;
        r.add_status = admit_task(item.budget, item.task_period);
      end else begin
        r = run_tick();
      end
      dispatch_q.push_back(r);
    endfunction

    function void check_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (dispatch_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual %p", $time, got);
        return;
      end
      want = dispatch_q.pop_front();
      check_field("running_task",  8'(want.running_task),  8'(got.running_task));
      check_field("deadline_miss", 8'(want.deadline_miss), 8'(got.deadline_miss));
      check_field("missed_task",   8'(want.missed_task),   8'(got.missed_task));
      check_field("add_status",    8'(want.add_status),    8'(got.add_status));
    endfunction

    function int pending();
      return dispatch_q.size();
    endfunction
  endclass

endpackage

FILE: sim/tb_edf_task_scheduler.sv
`timescale 1ns / 100ps
// Top-level testbench for edf_task_scheduler: directed and random tick/add
// transactions under varying idle patterns, checked against the scoreboard.
// Depends on edf_pkg, edf_sched_sb_pkg and the scheduler RTL.
module tb_edf_task_scheduler;
  import edf_pkg::*;
  import edf_sched_sb_pkg::*;

  localparam int LIMIT_CYCLES     = 1_000_000;
  localparam int RANDOM_PER_PHASE = 517;
  // Extra cycles after the last result, well past the longest tick or add.
  localparam int DRAIN_CYCLES     = 80;
  localparam int HOLD_CYCLES      = 400;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // Idle rates in percent per cycle; the stimulus process moves them per phase.
  int          sender_idle_pct;
  int          receiver_idle_pct;
  logic        hold_req;
  int unsigned cycle_count;

  edf_dispatch_scoreboard sched_sb = new();

  edf_task_scheduler DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: count cycles and give up at a generous limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("edf_task_scheduler test failed");
    $finish;
  end

  // Offer one transaction and hold it until the block takes it. An idle gap
  // may come first; valid is dropped only while the gap lasts.
  task automatic send_item(input logic op, input logic [7:0] bud, input logic [7:0] per);
    in_item_t item;
    item.op          = op;
    item.budget      = bud;
    item.task_period = per;
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    // Treat an unknown stall as a stall so the transaction is not lost.
    while (in_stall !== 1'b0) @(posedge clk);
    sched_sb.note_input(item);
  endtask

  // Mostly ticks; adds split between fully random operands (mostly refused,
  // and covering every bit) and low-utilization ones that fill the table.
  task automatic send_random_item();
    if ($urandom_range(99) < 15) begin
      if ($urandom_range(1) == 1)
        send_item(OP_ADD, 8'($urandom_range(255)), 8'($urandom_range(255)));
      else
        send_item(OP_ADD, 8'($urandom_range(3)), 8'($urandom_range(255, 16)));
    end else begin
      // Unused payload fields carry noise on a tick.
      send_item(OP_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end
  endtask

  // Result side: check each transaction taken at the edge, then pick the
  // stall for the next cycle. The long hold-off is counted here.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        sched_sb.check_result(out_data);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
    end
  end

  initial begin
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_data           <= '0;
    hold_req          <= 1'b0;
    sender_idle_pct   = 21;
    receiver_idle_pct <= 85;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-table tick, refused adds, the never-ready task, then
    // three tasks sharing one period so the first ticks exercise both
    // tie-breaks, and enough ticks to pass a period reload.
    send_item(OP_TICK, 8'd0,   8'd0);     // idle on an empty table
    send_item(OP_ADD,  8'd5,   8'd0);     // zero period: refused on utilization
    send_item(OP_ADD,  8'd255, 8'd255);   // utilization exactly one: refused
    send_item(OP_ADD,  8'd1,   8'd1);     // same, smallest operands
    send_item(OP_ADD,  8'd255, 8'd1);     // far over one
    send_item(OP_ADD,  8'd0,   8'd255);   // zero budget: admitted, never ready
    send_item(OP_TICK, 8'd255, 8'd255);   // idle with a task present
    send_item(OP_ADD,  8'd2,   8'd8);
    send_item(OP_ADD,  8'd1,   8'd8);
    send_item(OP_ADD,  8'd1,   8'd8);
    repeat (10) send_item(OP_TICK, 8'd0, 8'd0);

    // Phase 1: sender mostly busy, receiver mostly stalled.
    repeat (RANDOM_PER_PHASE) send_random_item();

    // Phase 2: swap the idle rates.
    sender_idle_pct   = 85;
    receiver_idle_pct <= 21;
    repeat (RANDOM_PER_PHASE) send_random_item();

    // Phase 3: no idling, but start with a long receiver hold-off so the
    // output backs up and the block stalls its input.
    sender_idle_pct   = 0;
    receiver_idle_pct <= 0;
    hold_req          <= 1'b1;
    repeat (RANDOM_PER_PHASE) send_random_item();

    in_valid <= 1'b0;
    while (sched_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sched_sb.errors == 0) begin
      $display("edf_task_scheduler test passed");
    end else begin
      $display("edf_task_scheduler test failed");
    end
    $finish;
  end

endmodule
